[src/ompm_pkg.sv]
// Shared types, constants and helpers for the ordered multi-string prefix matcher.
// No dependencies; every other file of the block imports this package, except ompm_ram.
`default_nettype none
package ompm_pkg;

	// Table geometry: positions x byte values
	localparam int TABLE_DEPTH = 16;
	localparam int NPAT        = 32;
	localparam int POS_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int ADDR_W      = POS_W + 8;
	localparam int MEM_DEPTH   = TABLE_DEPTH * 256;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int PIDX_W      = 5;
	localparam int LEN_W       = 5;

	// Item function codes
	localparam logic [1:0] FUNC_CLEAR = 2'd0;
	localparam logic [1:0] FUNC_ADD   = 2'd1;
	localparam logic [1:0] FUNC_MATCH = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_NOMATCH = 2'd0;
	localparam logic [1:0] ST_SHORT   = 2'd1;
	localparam logic [1:0] ST_MATCH   = 2'd2;

	typedef struct packed {
		logic [1:0]        func;
		logic [7:0]        char_code;
		logic [PIDX_W-1:0] pattern_index;
		logic [3:0]        char_position;
		logic              ends_pattern;
		logic              ends_subject;
	} item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [PIDX_W-1:0] matched_pattern;
		logic [LEN_W-1:0]  match_length;
	} result_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic clr_wr;
		logic match_rd;
		logic match_eval;
		logic add_rd;
		logic add_wr;
		logic add_wr2;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic clr_last;
		logic fold_other;
		logic pos_ok;
	} sts_t;

	// Encode a one-hot (or zero) pattern vector into its index
	function automatic logic [PIDX_W-1:0] onehot_idx(input logic [NPAT-1:0] oh);
		logic [PIDX_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < NPAT; i++) begin
			if (oh[i]) begin
				idx = idx | PIDX_W'(i);
			end
		end
		return idx;
	endfunction

endpackage
`default_nettype wire

[src/ompm_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none
module ompm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[src/ompm_ctrl.sv]
// Controller state machine of the prefix matcher: sequences clear sweeps,
// read-modify-write adds and match steps. Depends on ompm_pkg.
`default_nettype none
module ompm_ctrl
	import ompm_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	input  wire item_t item,
	input  wire sts_t  sts,
	output logic       busy,
	output cmd_t       cmd
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_CLEAR = 7'b0000010,
		S_MRD   = 7'b0000100,
		S_MEVAL = 7'b0001000,
		S_ARD   = 7'b0010000,
		S_AWR   = 7'b0100000,
		S_AWR2  = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   load;

	assign busy = (state_q != S_IDLE);
	assign load = start && !busy;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (load) begin
					case (item.func)
						FUNC_CLEAR: state_d = S_CLEAR;
						FUNC_ADD:   state_d = sts.pos_ok ? S_ARD : S_IDLE;
						FUNC_MATCH: state_d = S_MRD;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_CLEAR: begin
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_MRD:   state_d = S_MEVAL;
			S_MEVAL: state_d = S_IDLE;
			S_ARD:   state_d = S_AWR;
			S_AWR:   state_d = sts.fold_other ? S_AWR2 : S_IDLE;
			S_AWR2:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Sweep the tables clear out of reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Decode commands
	always_comb begin
		cmd            = '0;
		cmd.load       = load;
		cmd.clr_wr     = (state_q == S_CLEAR);
		cmd.match_rd   = (state_q == S_MRD);
		cmd.match_eval = (state_q == S_MEVAL);
		cmd.add_rd     = (state_q == S_ARD);
		cmd.add_wr     = (state_q == S_AWR);
		cmd.add_wr2    = (state_q == S_AWR2);
	end

endmodule
`default_nettype wire

[src/ompm_dp.sv]
// Datapath of the prefix matcher: mask tables, matcher state and result register.
// Depends on ompm_pkg and ompm_ram.
`default_nettype none
module ompm_dp
	import ompm_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire item_t item,
	input  wire logic  cfg_wr,
	input  wire logic  cfg_data,
	input  wire cmd_t  cmd,
	output sts_t       sts,
	output logic       done,
	output result_t    result
);

	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LZ     = 8'h7A;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UZ     = 8'h5A;
	localparam logic [7:0] CASE_DIFF = 8'd32;

	item_t             item_q;
	logic              fold_case_q;
	logic [ADDR_W-1:0] clr_q;

	logic [NPAT-1:0]   alive_q, ended_q;
	logic [CNT_W-1:0]  best_q, pos_q;
	logic              decided_q;

	logic              done_q;
	result_t           result_q;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [NPAT-1:0]   cont_wdata, end_wdata, cont_rd, end_rd;

	logic [7:0]        other_ch;
	logic              is_lower, is_upper;
	logic [POS_W-1:0]  add_pos;
	logic [NPAT-1:0]   pat_bit;

	// Latch the accepted beat
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
	end

	// Hold the case-fold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_case_q <= 1'b0;
		end else if (cfg_wr) begin
			fold_case_q <= cfg_data;
		end
	end

	// Advance the clear sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_q <= sts.clr_last ? '0 : clr_q + 1'b1;
		end
	end

	// Other-case letter for folded adds
	assign is_lower = (item_q.char_code >= CH_LA) && (item_q.char_code <= CH_LZ);
	assign is_upper = (item_q.char_code >= CH_UA) && (item_q.char_code <= CH_UZ);
	assign other_ch = is_lower ? (item_q.char_code - CASE_DIFF)
	                           : (item_q.char_code + CASE_DIFF);
	assign add_pos  = POS_W'(item_q.char_position);
	assign pat_bit  = {{(NPAT-1){1'b0}}, 1'b1} << item_q.pattern_index;

	assign sts.clr_last   = (clr_q == ADDR_W'(MEM_DEPTH - 1));
	assign sts.fold_other = fold_case_q && (is_lower || is_upper);
	assign sts.pos_ok     = (int'(item.char_position) < TABLE_DEPTH);

	// Table port addressing and write data
	always_comb begin
		ram_we     = cmd.clr_wr || cmd.add_wr || cmd.add_wr2;
		ram_waddr  = '0;
		ram_raddr  = '0;
		cont_wdata = '0;
		end_wdata  = '0;
		if (cmd.clr_wr) begin
			ram_waddr = clr_q;
		end else if (cmd.add_wr) begin
			ram_waddr = {add_pos, item_q.char_code};
		end else if (cmd.add_wr2) begin
			ram_waddr = {add_pos, other_ch};
		end
		if (cmd.add_wr || cmd.add_wr2) begin
			cont_wdata = cont_rd | pat_bit;
			end_wdata  = end_rd | (item_q.ends_pattern ? pat_bit : '0);
		end
		if (cmd.add_rd) begin
			ram_raddr = {add_pos, item_q.char_code};
		end else if (cmd.add_wr) begin
			ram_raddr = {add_pos, other_ch};
		end else if (cmd.match_rd) begin
			ram_raddr = {POS_W'(pos_q), item_q.char_code};
		end
	end

	ompm_ram #(.WIDTH(NPAT), .DEPTH(MEM_DEPTH)) u_cont_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (cont_wdata),
		.raddr (ram_raddr),
		.rdata (cont_rd)
	);

	ompm_ram #(.WIDTH(NPAT), .DEPTH(MEM_DEPTH)) u_end_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (end_wdata),
		.raddr (ram_raddr),
		.rdata (end_rd)
	);

	// Match step evaluation
	logic [NPAT-1:0]  cur, hit, head, ended_new, ended_low;
	logic [CNT_W-1:0] pos_inc, best_new;
	logic             emit;
	result_t          res_d;

	always_comb begin
		cur       = (int'(pos_q) < TABLE_DEPTH) ? (alive_q & cont_rd) : '0;
		hit       = end_rd & cur;
		head      = cur & (~cur + 1'b1);
		pos_inc   = pos_q + 1'b1;
		ended_new = (hit != '0) ? hit : ended_q;
		best_new  = (hit != '0) ? pos_inc : best_q;
		ended_low = ended_new & (~ended_new + 1'b1);
		emit      = 1'b0;
		res_d     = '0;
		if (!decided_q) begin
			if (cur == '0) begin
				emit = 1'b1;
				if (best_q != '0) begin
					res_d.status          = ST_MATCH;
					res_d.matched_pattern = onehot_idx(ended_low);
					res_d.match_length    = LEN_W'(best_q);
				end else begin
					res_d.status = ST_NOMATCH;
				end
			end else if ((hit & head) != '0) begin
				emit                  = 1'b1;
				res_d.status          = ST_MATCH;
				res_d.matched_pattern = onehot_idx(head);
				res_d.match_length    = LEN_W'(pos_inc);
			end else if (item_q.ends_subject || (int'(pos_inc) >= TABLE_DEPTH)) begin
				emit = 1'b1;
				if (best_new != '0) begin
					res_d.status          = ST_MATCH;
					res_d.matched_pattern = onehot_idx(ended_low);
					res_d.match_length    = LEN_W'(best_new);
				end else begin
					res_d.status = ST_SHORT;
				end
			end
		end
	end

	// Update matcher state; restart on the last subject byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q   <= '1;
			ended_q   <= '0;
			best_q    <= '0;
			pos_q     <= '0;
			decided_q <= 1'b0;
		end else if (cmd.match_eval) begin
			if (item_q.ends_subject) begin
				alive_q   <= '1;
				ended_q   <= '0;
				best_q    <= '0;
				pos_q     <= '0;
				decided_q <= 1'b0;
			end else if (!decided_q) begin
				if (cur != '0) begin
					alive_q <= cur;
					pos_q   <= pos_inc;
					ended_q <= ended_new;
					best_q  <= best_new;
				end
				decided_q <= emit;
			end
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.match_eval && emit;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.match_eval && emit) begin
			result_q <= res_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

[src/ordered_multi_string_prefix_matcher.sv]
// Ordered multi-string prefix matcher, top level.
// Holds up to 32 patterns in continue/end mask tables and matches subject bytes.
// Channels: an item is taken at a clock edge with start high and busy low; func
// selects clear tables, add pattern character or match subject byte.
// A match beat produces at most one result, shown on result for one cycle with
// done high; the receiver cannot stall, so every result is taken as it appears.
// fold_case is written through cfg_valid/cfg_ready/cfg_data; cfg_ready is
// always high. The user makes writes while the block is idle; it is not enforced.
// Sequencing, set by the controller around the registered table read:
//   match: read and evaluate states, then back to idle; done is registered
//          from the evaluate state.
//   add:   read, write, and a second write of the other-case letter if folding.
//   clear: one table word zeroed per cycle across all TABLE_DEPTH*256 words.
// Reset: the controller sweeps both tables to zero with busy high;
// configuration writes are taken meanwhile.
// Matcher state and fold_case come out of reset cleared (all patterns alive).
// Depends on ompm_pkg, ompm_ctrl, ompm_dp and ompm_ram.
`default_nettype none
module ordered_multi_string_prefix_matcher
	import ompm_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	output logic       busy,
	input  wire item_t item,
	output logic       done,
	output result_t    result,
	input  wire logic  cfg_valid,
	output logic       cfg_ready,
	input  wire logic  cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	ompm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	ompm_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cfg_wr   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts),
		.done     (done),
		.result   (result)
	);

`ifndef SYNTHESIS
	// A result only follows an evaluate cycle
	a_done_after_eval: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(cmd.match_eval))
		else $error("result without a preceding match evaluation");

	// The controller is back in idle while a result is shown
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// Status is a defined code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status == ST_NOMATCH || result.status == ST_SHORT ||
		          result.status == ST_MATCH))
		else $error("undefined result status");

	// Non-match results carry zero pattern and length
	a_nomatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_MATCH) |->
		(result.matched_pattern == '0 && result.match_length == '0))
		else $error("non-match result carries pattern or length");

	// A match has a nonzero length
	a_match_len: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_MATCH) |-> (result.match_length != '0))
		else $error("match reported with zero length");
`endif

endmodule
`default_nettype wire

[tb/ordered_multi_string_prefix_matcher_tb.sv]
// Testbench for the ordered multi-string prefix matcher: directed and random pattern
// sets, subjects built from them, and a mask-table predictor checked beat by beat.
// Depends on ompm_pkg and the ordered_multi_string_prefix_matcher top level.
`timescale 1ns / 1ps

module ordered_multi_string_prefix_matcher_tb;
	import ompm_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int ITEM_W = $bits(item_t);
	localparam int MAX_PATS = 4;
	localparam logic [7:0] CASE_BIT = 8'h20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	item_t item_in = '0;
	logic cfg_valid = 1'b0;
	logic cfg_data = 1'b0;
	logic busy, done, cfg_ready;
	result_t dut_res;

	ordered_multi_string_prefix_matcher dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item_in),
		.done(done),
		.result(dut_res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// Stimulus bookkeeping
	item_t pend_q[$];
	result_t exp_results[$];
	int n_pushed = 0;
	int n_taken = 0;
	int n_stim = 0;
	int n_err = 0;
	int idle_pct = 0;
	logic took_beat = 1'b0;

	// Predictor state: mask tables, matcher progress and the case-fold register
	logic [31:0] cont_tbl [TABLE_DEPTH][256];
	logic [31:0] end_tbl [TABLE_DEPTH][256];
	logic [31:0] alive_m;
	logic [31:0] ended_m;
	int best_len_m;
	int subj_pos_m;
	bit decided_m;
	logic fold_m = 1'b0;

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		n_err++;
		$display("MISMATCH @%0t: %s", $time, msg);
	endtask

	function automatic void wipe_tables();
		for (int p = 0; p < TABLE_DEPTH; p++) begin
			for (int c = 0; c < 256; c++) begin
				cont_tbl[p][c] = '0;
				end_tbl[p][c] = '0;
			end
		end
	endfunction

	function automatic void restart_subject();
		alive_m = '1;
		ended_m = '0;
		best_len_m = 0;
		subj_pos_m = 0;
		decided_m = 1'b0;
	endfunction

	function automatic int lowest_pattern(input logic [31:0] m);
		for (int i = 0; i < 32; i++) begin
			if (m[i]) begin
				return i;
			end
		end
		return 0;
	endfunction

	function automatic logic [7:0] other_case(input logic [7:0] c);
		if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
			return c ^ CASE_BIT;
		end
		return c;
	endfunction

	// Apply one beat to the predictor; return 1 with the result when a decision is made
	function automatic bit predict_prefix_match(input item_t it, output result_t r);
		logic [31:0] cur, hits, head, pbit;
		logic [7:0] alt;
		int pos;
		bit got;
		got = 1'b0;
		r = '0;
		case (it.func)
			FUNC_CLEAR: begin
				wipe_tables();
			end
			FUNC_ADD: begin
				if (int'(it.char_position) < TABLE_DEPTH) begin
					pos = int'(it.char_position);
					pbit = 32'd1 << it.pattern_index;
					alt = other_case(it.char_code);
					cont_tbl[pos][it.char_code] |= pbit;
					if (it.ends_pattern) begin
						end_tbl[pos][it.char_code] |= pbit;
					end
					// folding sets the other case of a letter too
					if (fold_m && alt != it.char_code) begin
						cont_tbl[pos][alt] |= pbit;
						if (it.ends_pattern) begin
							end_tbl[pos][alt] |= pbit;
						end
					end
				end
			end
			FUNC_MATCH: begin
				if (!decided_m) begin
					pos = subj_pos_m;
					cur = '0;
					if (pos < TABLE_DEPTH) begin
						cur = alive_m & cont_tbl[pos][it.char_code];
					end
					if (cur == '0) begin
						// nothing alive: fall back to the remembered end
						got = 1'b1;
						decided_m = 1'b1;
						if (best_len_m != 0) begin
							r.status = ST_MATCH;
							r.matched_pattern = PIDX_W'(lowest_pattern(ended_m));
							r.match_length = LEN_W'(best_len_m);
						end else begin
							r.status = ST_NOMATCH;
						end
					end else begin
						hits = end_tbl[pos][it.char_code] & cur;
						head = cur & (~cur + 32'd1);
						if (hits != '0) begin
							best_len_m = pos + 1;
							ended_m = hits;
							// the highest-priority alive pattern ended: done at once
							if ((hits & head) != '0) begin
								got = 1'b1;
								decided_m = 1'b1;
								r.status = ST_MATCH;
								r.matched_pattern = PIDX_W'(lowest_pattern(head));
								r.match_length = LEN_W'(best_len_m);
							end
						end
						alive_m = cur;
						subj_pos_m = pos + 1;
						// subject exhausted or table depth reached
						if (!decided_m && (it.ends_subject || subj_pos_m >= TABLE_DEPTH)) begin
							got = 1'b1;
							decided_m = 1'b1;
							if (best_len_m != 0) begin
								r.status = ST_MATCH;
								r.matched_pattern = PIDX_W'(lowest_pattern(ended_m));
								r.match_length = LEN_W'(best_len_m);
							end else begin
								r.status = ST_SHORT;
							end
						end
					end
				end
				if (it.ends_subject) begin
					restart_subject();
				end
			end
			default: ;
		endcase
		return got;
	endfunction

	initial begin
		wipe_tables();
		restart_subject();
	end

	// Driver: present the next pending beat at the falling edge, idle at random
	always @(negedge clk) begin
		if (!start || took_beat) begin
			if (pend_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
				item_in <= pend_q.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: check results, track config writes, predict accepted beats
	always @(posedge clk) begin
		result_t want, next_exp;
		if (arst_n) begin
			if (done === 1'b1) begin
				if (exp_results.size() == 0) begin
					report_mismatch($sformatf("result with none expected: status %0d pattern %0d len %0d",
						dut_res.status, dut_res.matched_pattern, dut_res.match_length));
				end else begin
					want = exp_results.pop_front();
					if (dut_res.status !== want.status) begin
						report_mismatch($sformatf("status got %0d want %0d",
							dut_res.status, want.status));
					end
					if (dut_res.matched_pattern !== want.matched_pattern) begin
						report_mismatch($sformatf("matched_pattern got %0d want %0d",
							dut_res.matched_pattern, want.matched_pattern));
					end
					if (dut_res.match_length !== want.match_length) begin
						report_mismatch($sformatf("match_length got %0d want %0d",
							dut_res.match_length, want.match_length));
					end
				end
			end
			if (cfg_valid && cfg_ready === 1'b1) begin
				fold_m = cfg_data;
			end
			if (start && busy === 1'b0) begin
				if (predict_prefix_match(item_in, next_exp)) begin
					exp_results.push_back(next_exp);
				end
				n_taken <= n_taken + 1;
			end
			took_beat <= start && busy === 1'b0;
		end else begin
			took_beat <= 1'b0;
		end
	end

	// Beat builders; fields the function ignores carry random values
	function automatic item_t rand_item();
		return item_t'(ITEM_W'($urandom));
	endfunction

	function automatic item_t clear_beat();
		item_t it;
		it = rand_item();
		it.func = FUNC_CLEAR;
		return it;
	endfunction

	function automatic item_t add_beat(input int pos, input logic [7:0] ch, input int idx,
		input bit last);
		item_t it;
		it = rand_item();
		it.func = FUNC_ADD;
		it.char_position = 4'(pos);
		it.char_code = ch;
		it.pattern_index = PIDX_W'(idx);
		it.ends_pattern = last;
		return it;
	endfunction

	function automatic item_t match_beat(input logic [7:0] ch, input bit last);
		item_t it;
		it = rand_item();
		it.func = FUNC_MATCH;
		it.char_code = ch;
		it.ends_subject = last;
		return it;
	endfunction

	function automatic item_t noise_beat();
		item_t it;
		it = rand_item();
		it.func = 2'($urandom_range(1, 3));
		return it;
	endfunction

	// Mostly letters and their neighbors so that patterns overlap and folding matters
	function automatic logic [7:0] pick_char();
		logic [7:0] common [8] = '{"a", "b", "z", "A", "B", "Z", "@", "{"};
		if ($urandom_range(9) < 7) begin
			return common[$urandom_range(7)];
		end
		return 8'($urandom);
	endfunction

	task automatic push_item(input item_t it);
		do @(posedge clk); while (pend_q.size() >= 4);
		pend_q.push_back(it);
		n_pushed++;
		if (it.func != FUNC_UNUSED) begin
			n_stim++;
		end
	endtask

	// Hold until every pushed beat is taken, every result is in and the block is idle
	task automatic wait_idle();
		do @(negedge clk); while (n_taken != n_pushed || exp_results.size() != 0 || busy !== 1'b0);
		repeat (3) @(negedge clk);
	endtask

	// Called at a falling edge with the block idle
	task automatic write_fold(input logic v);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// One set of patterns, then subjects drawn from them with some damage
	task automatic run_pattern_set();
		int npat, slen, k, cut, bad;
		int pidx [MAX_PATS];
		int plen [MAX_PATS];
		bit pend [MAX_PATS];
		logic [7:0] pch [MAX_PATS][TABLE_DEPTH];
		logic [7:0] c;
		bit flip;
		if ($urandom_range(2) == 0) begin
			push_item(clear_beat());
		end
		npat = $urandom_range(1, MAX_PATS);
		for (int p = 0; p < npat; p++) begin
			case ($urandom_range(4))
				0: pidx[p] = 0;
				1: pidx[p] = 31;
				default: pidx[p] = $urandom_range(31);
			endcase
			plen[p] = ($urandom_range(4) == 0) ? $urandom_range(10, TABLE_DEPTH) : $urandom_range(1, 5);
			// a few patterns are left without an end mark
			pend[p] = ($urandom_range(9) != 0);
			// later patterns often share a prefix with the first
			cut = (p > 0 && $urandom_range(1) == 1) ? $urandom_range(1, plen[0]) : 0;
			for (int i = 0; i < plen[p]; i++) begin
				pch[p][i] = (i < cut) ? pch[0][i] : pick_char();
			end
		end
		for (int p = 0; p < npat; p++) begin
			for (int i = 0; i < plen[p]; i++) begin
				push_item(add_beat(i, pch[p][i], pidx[p], pend[p] && i == plen[p] - 1));
				if ($urandom_range(19) == 0) begin
					push_item(noise_beat());
				end
			end
		end
		repeat ($urandom_range(2, 5)) begin
			k = $urandom_range(npat - 1);
			flip = ($urandom_range(1) == 1);
			slen = ($urandom_range(3) == 0) ? $urandom_range(1, plen[k]) : plen[k] + $urandom_range(3);
			bad = ($urandom_range(5) == 0) ? $urandom_range(slen - 1) : -1;
			for (int i = 0; i < slen; i++) begin
				c = (i >= plen[k] || i == bad) ? pick_char() : pch[k][i];
				if (flip && $urandom_range(1) == 1) begin
					c = other_case(c);
				end
				push_item(match_beat(c, i == slen - 1));
				if ($urandom_range(29) == 0) begin
					push_item(noise_beat());
				end
			end
		end
	endtask

	task automatic run_random(input int count);
		int stop;
		stop = n_stim + count;
		while (n_stim < stop) begin
			run_pattern_set();
			// now and then let everything drain before the next set
			if ($urandom_range(3) == 0) begin
				wait_idle();
			end
		end
	endtask

	// Main sequence
	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		wait_idle();
		write_fold(1'b1);
		idle_pct = 27;

		// Directed: folding, priority, remembered ends, too short, clear keeps matcher state
		push_item(clear_beat());
		push_item(add_beat(0, "A", 0, 1'b0));
		push_item(add_beat(1, "b", 0, 1'b1));
		push_item(add_beat(0, "a", 31, 1'b1));
		push_item(add_beat(0, 8'h00, 7, 1'b0));
		push_item(add_beat(15, 8'hFF, 5, 1'b1));
		push_item(item_t'('1));
		push_item(match_beat("a", 1'b0));
		push_item(match_beat("B", 1'b0));
		push_item(match_beat("x", 1'b1));
		push_item(match_beat("a", 1'b1));
		push_item(match_beat("a", 1'b0));
		push_item(match_beat("z", 1'b0));
		push_item(match_beat("q", 1'b1));
		push_item(match_beat("q", 1'b1));
		push_item(match_beat(8'h00, 1'b1));
		push_item(match_beat("A", 1'b0));
		push_item(clear_beat());
		push_item(match_beat("b", 1'b1));

		wait_idle();
		write_fold(1'b0);
		run_random(150);

		wait_idle();
		idle_pct = 76;
		write_fold(1'b1);
		run_random(150);

		wait_idle();
		idle_pct = 0;
		write_fold(1'b0);
		run_random(150);

		// Drain: all beats taken, then give late results a bounded chance
		do @(negedge clk); while (n_taken != n_pushed || busy !== 1'b0);
		for (int i = 0; i < 50 && exp_results.size() != 0; i++) begin
			@(negedge clk);
		end
		repeat (10) @(negedge clk);
		if (exp_results.size() != 0) begin
			report_mismatch($sformatf("%0d expected results never arrived", exp_results.size()));
		end
		if (n_err == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Watchdog: reset sweep, a few dozen table clears and the beats fit well inside this
	initial begin
		#15_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
